### rtl/core/hsd_pkg.sv
package hsd_pkg;

  // Default largest data length per codeword
  localparam int MaxDataBitsDef = 255;

  // Longest parity search; covers any data length up to 32752
  localparam int ParitySearch = 15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_SYN,
    ST_DATA,
    ST_FLUSH
  } hsd_state_e;

  // One finished data word handed to the output stage
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       err;
  } hsd_push_t;

  // Output stage status seen by the sequencer
  typedef struct packed {
    logic stage_full;
    logic out_free;
  } hsd_stat_t;

  // Least k with 2^k >= k + d + 1
  function automatic int parity_count(input int d);
    int k;
    k = ParitySearch;
    for (int j = ParitySearch; j >= 1; j--) begin
      if ((1 << j) >= j + d + 1) begin
        k = j;
      end
    end
    return k;
  endfunction

  // Codeword length for a raw register value, clamped to 1..max_d
  function automatic int code_len(input int d, input int max_d);
    int e;
    e = d;
    if (e < 1) begin
      e = 1;
    end
    if (e > max_d) begin
      e = max_d;
    end
    return e + parity_count(e);
  endfunction

endpackage

### rtl/core/hsd_bit_mem.sv
module hsd_bit_mem #(
  parameter int AddrW = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);

  logic mem_q [2**AddrW];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/hsd_out_stage.sv
module hsd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hsd_pkg::hsd_push_t  push_i,
  input  logic                flush_i,
  output hsd_pkg::hsd_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          data_byte_o,
  output logic                error_seen_o,
  output logic                last_o
);

  import hsd_pkg::*;

  logic       stage_full_q, stage_full_d;
  logic [7:0] stage_data_q, stage_data_d;
  logic       stage_err_q, stage_err_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_err_q, out_err_d;
  logic       out_last_q, out_last_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stage_full_d = stage_full_q;
    stage_data_d = stage_data_q;
    stage_err_d  = stage_err_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    out_err_d    = out_err_q;
    out_last_d   = out_last_q;
    // A held word moves out once the next one shows up (not last) or on flush (last)
    if ((push_i.valid || flush_i) && stage_full_q) begin
      out_valid_d = 1'b1;
      out_data_d  = stage_data_q;
      out_err_d   = stage_err_q;
      out_last_d  = flush_i;
    end
    if (push_i.valid) begin
      stage_full_d = 1'b1;
      stage_data_d = push_i.data;
      stage_err_d  = push_i.err;
    end else if (flush_i) begin
      stage_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_full_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      stage_full_q <= stage_full_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_data_q <= stage_data_d;
    stage_err_q  <= stage_err_d;
    out_data_q   <= out_data_d;
    out_err_q    <= out_err_d;
    out_last_q   <= out_last_d;
  end

  assign stat_o.stage_full = stage_full_q;
  assign stat_o.out_free   = out_free;
  assign out_valid_o       = out_valid_q;
  assign data_byte_o       = out_data_q;
  assign error_seen_o      = out_err_q;
  assign last_o            = out_last_q;

endmodule

### rtl/core/hsd_core.sv
module hsd_core #(
  parameter int LenW = 9,
  parameter int PtrW = 9,
  parameter int CntW = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [LenW-1:0]     cw_len_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          coded_byte_i,
  input  logic                restart_i,
  output logic                mem_we_o,
  output logic [PtrW-1:0]     mem_waddr_o,
  output logic                mem_wdata_o,
  output logic                mem_re_o,
  output logic [PtrW-1:0]     mem_raddr_o,
  input  logic                mem_rdata_i,
  output hsd_pkg::hsd_push_t  push_o,
  output logic                flush_o,
  input  hsd_pkg::hsd_stat_t  stat_i
);

  import hsd_pkg::*;

  hsd_state_e state_q, state_d;

  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      load_q, load_d;
  logic [2:0]      bit_cnt_q, bit_cnt_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic [LenW-1:0] rd_pos_q, rd_pos_d;
  logic [LenW-1:0] syn_q, syn_d;
  logic [6:0]      pend_q, pend_d;
  logic [2:0]      pend_cnt_q, pend_cnt_d;

  logic in_pass, issue, consume, pass_done;
  logic is_par, completes, bit_now, emit_ok;

  // Position tests for the bit coming back from the buffer
  assign is_par    = (rd_pos_q & (rd_pos_q - LenW'(1))) == '0;
  assign bit_now   = mem_rdata_i ^ (rd_pos_q == syn_q);
  assign completes = !is_par && (pend_cnt_q == 3'd7);
  assign emit_ok   = !stat_i.stage_full || stat_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (bit_cnt_q == 3'd7) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = (count_q >= CntW'(cw_len_i)) ? ST_SYN : ST_FLUSH;
      end
      ST_SYN: begin
        if (pass_done) begin
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (pass_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_FLUSH: begin
        if (emit_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_we_o   = 1'b0;
    in_pass    = 1'b0;
    consume    = 1'b0;
    flush_o    = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_LOAD:  mem_we_o = 1'b1;
      ST_CHECK: in_pass = 1'b0;
      ST_SYN: begin
        in_pass = 1'b1;
        consume = rd_vld_q;
      end
      ST_DATA: begin
        in_pass = 1'b1;
        // stall on a full word the output side cannot take yet
        consume = rd_vld_q && (!completes || emit_ok);
      end
      ST_FLUSH: flush_o = stat_i.stage_full && stat_i.out_free;
      default:  in_ready_o = 1'b0;
    endcase
  end

  assign issue     = in_pass && (idx_q < cw_len_i) && (!rd_vld_q || consume);
  assign pass_done = consume && (rd_pos_q == cw_len_i);

  assign mem_waddr_o = rd_ptr_q + count_q[PtrW-1:0];
  assign mem_wdata_o = load_q[7];
  assign mem_re_o    = issue;
  assign mem_raddr_o = rd_ptr_q + PtrW'(idx_q);

  assign push_o.valid = (state_q == ST_DATA) && consume && completes;
  assign push_o.data  = {pend_q, bit_now};
  assign push_o.err   = syn_q != '0;

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    count_d    = count_q;
    load_d     = load_q;
    bit_cnt_d  = bit_cnt_q;
    idx_d      = idx_q;
    rd_vld_d   = rd_vld_q;
    rd_pos_d   = rd_pos_q;
    syn_d      = syn_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;

    if (state_q == ST_IDLE && in_valid_i) begin
      load_d    = coded_byte_i;
      bit_cnt_d = '0;
      if (restart_i) begin
        count_d    = '0;
        pend_cnt_d = '0;
      end
    end

    // Append one coded bit per cycle, MSB first
    if (state_q == ST_LOAD) begin
      load_d    = {load_q[6:0], 1'b0};
      count_d   = count_q + CntW'(1);
      bit_cnt_d = bit_cnt_q + 3'd1;
    end

    if (state_q == ST_CHECK) begin
      idx_d    = '0;
      rd_vld_d = 1'b0;
      syn_d    = '0;
    end

    // Read pipeline shared by both passes
    if (issue) begin
      idx_d    = idx_q + LenW'(1);
      rd_vld_d = 1'b1;
      rd_pos_d = idx_q + LenW'(1);
    end else if (consume) begin
      rd_vld_d = 1'b0;
    end

    if (state_q == ST_SYN && consume) begin
      if (mem_rdata_i) begin
        syn_d = syn_q ^ rd_pos_q;
      end
      if (pass_done) begin
        idx_d = '0;
      end
    end

    if (state_q == ST_DATA && consume) begin
      if (!is_par) begin
        pend_d     = {pend_q[5:0], bit_now};
        pend_cnt_d = completes ? 3'd0 : pend_cnt_q + 3'd1;
      end
      // drop the decoded codeword from the buffer
      if (pass_done) begin
        rd_ptr_d = rd_ptr_q + PtrW'(cw_len_i);
        count_d  = count_q - CntW'(cw_len_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_ptr_q   <= '0;
      count_q    <= '0;
      bit_cnt_q  <= '0;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      pend_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      rd_ptr_q   <= rd_ptr_d;
      count_q    <= count_d;
      bit_cnt_q  <= bit_cnt_d;
      idx_q      <= idx_d;
      rd_vld_q   <= rd_vld_d;
      pend_cnt_q <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    load_q   <= load_d;
    rd_pos_q <= rd_pos_d;
    syn_q    <= syn_d;
    pend_q   <= pend_d;
  end

endmodule

### rtl/core/hamming_stream_decoder.sv
// Operation: an accepted byte has its bits written into the bit buffer, then a check
// step; each complete codeword then gets one syndrome read pass and one extract pass
// over the bit memory, and a final flush step closes the byte. A new byte is taken only
// after the previous one is done, and stalls on the output side delay it. Reset
// (rst_ni low, asynchronous) empties the buffers, drops any pending word and sets
// data_bits to 11; the bit memory itself needs no clearing.
module hamming_stream_decoder #(
  parameter int MAX_DATA_BITS = hsd_pkg::MaxDataBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] coded_byte_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       error_seen_o,
  output logic       last_o
);

  import hsd_pkg::*;

  // Longest codeword, and the buffer that holds its leftover plus one more byte
  localparam int MaxParity = parity_count(MAX_DATA_BITS);
  localparam int MaxN      = MAX_DATA_BITS + MaxParity;
  localparam int BufBits   = MaxN + 8;
  localparam int PtrW      = $clog2(BufBits);
  localparam int CntW      = $clog2(BufBits + 1);
  localparam int LenW      = $clog2(MaxN + 1);

  // Codeword length is worked out once per register write, with clamping of
  // zero up to one and of large values down to MAX_DATA_BITS.
  logic [LenW-1:0] cw_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_len_q <= LenW'(code_len(11, MAX_DATA_BITS));
    end else if (cfg_we_i) begin
      cw_len_q <= LenW'(code_len(int'(cfg_data_i), MAX_DATA_BITS));
    end
  end

  logic            mem_we, mem_wdata, mem_re, mem_rdata;
  logic [PtrW-1:0] mem_waddr, mem_raddr;
  hsd_push_t       push;
  hsd_stat_t       stat;
  logic            flush;

  // Circular bit buffer: pointer wraps naturally at the memory depth
  hsd_bit_mem #(
    .AddrW (PtrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer: load bits, syndrome pass, correct-and-pack pass, repeat per codeword.
  // The corrected bit is the one whose 1-based position equals the syndrome; parity
  // positions are skipped, so a syndrome naming a parity bit or lying past the
  // codeword leaves the data untouched.
  hsd_core #(
    .LenW (LenW),
    .PtrW (PtrW),
    .CntW (CntW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cw_len_i     (cw_len_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .coded_byte_i (coded_byte_i),
    .restart_i    (restart_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .push_o       (push),
    .flush_o      (flush),
    .stat_i       (stat)
  );

  // Hold each finished word one step so the final word of a byte can carry last
  hsd_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .flush_i      (flush),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_byte_o  (data_byte_o),
    .error_seen_o (error_seen_o),
    .last_o       (last_o)
  );

  // The sequencer is busy right after taking a byte
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a byte");

  // While idle, any word still waiting at the output closes its byte
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || last_o)
    else $error("idle with a word not marked last");

  // Codeword length stays within the supported range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw_len_q >= LenW'(3)) && (cw_len_q <= LenW'(MaxN)))
    else $error("codeword length out of range");

endmodule

### sim/hsd_checker.sv
`timescale 1ns / 100ps

module hsd_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] coded_byte_i,
  input  logic       restart_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic       error_seen_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         decoded_o
);

  localparam int BitCap = 272;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } data_word_t;

  logic [7:0] data_bits_q;
  logic       coded_q [BitCap];
  logic [8:0] coded_cnt;
  logic [7:0] part_byte;
  logic [3:0] part_cnt;
  data_word_t expected_q [$];
  int         fails = 0;
  int         words_seen = 0;

  // Take one coded word in, decode every complete codeword, queue the data words.
  task automatic decode_coded(input logic [7:0] cb, input logic rs);
    int d, k, n, syn, flip, didx, nres, lg;
    logic b, err;
    data_word_t w;
    d = (data_bits_q == 8'd0) ? 1 : int'(data_bits_q);
    k = 1;
    while ((1 << k) < k + d + 1) k++;
    n = d + k;
    nres = 0;
    if (rs) begin
      coded_cnt = '0;
      part_byte = '0;
      part_cnt  = '0;
    end
    for (int i = 7; i >= 0; i--) begin
      if (coded_cnt < BitCap) begin
        coded_q[coded_cnt] = cb[i];
        coded_cnt++;
      end
    end
    while (int'(coded_cnt) >= n) begin
      syn = 0;
      for (int p = 1; p <= n; p++) begin
        if (coded_q[p - 1]) syn ^= p;
      end
      err  = (syn != 0);
      flip = -1;
      // repair only a data position inside the codeword
      if (err && syn <= n && (syn & (syn - 1)) != 0) begin
        lg = 0;
        for (int v = syn; v != 0; v >>= 1) lg++;
        flip = syn - lg - 1;
      end
      didx = 0;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          b = coded_q[p - 1] ^ (didx == flip);
          didx++;
          part_byte = {part_byte[6:0], b};
          part_cnt++;
          if (part_cnt == 4'd8) begin
            w.data = part_byte;
            w.err  = err;
            w.last = 1'b0;
            expected_q = {expected_q, w};
            nres++;
            part_byte = '0;
            part_cnt  = '0;
          end
        end
      end
      for (int j = 0; j + n < int'(coded_cnt); j++) coded_q[j] = coded_q[j + n];
      coded_cnt = coded_cnt - 9'(n);
    end
    if (nres > 0) begin
      w = expected_q[expected_q.size() - 1];
      w.last = 1'b1;
      expected_q[expected_q.size() - 1] = w;
    end
  endtask

  task automatic check_word();
    data_word_t w;
    words_seen++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected data word: expected none, got %h (error_seen %b, last %b)",
               $time, data_byte_i, error_seen_i, last_i);
      fails++;
    end else begin
      w = expected_q.pop_front();
      if (data_byte_i !== w.data) begin
        $display("%0t: data_byte expected %h, got %h", $time, w.data, data_byte_i);
        fails++;
      end
      if (error_seen_i !== w.err) begin
        $display("%0t: error_seen expected %b, got %b", $time, w.err, error_seen_i);
        fails++;
      end
      if (last_i !== w.last) begin
        $display("%0t: last expected %b, got %b", $time, w.last, last_i);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q = 8'd11;
      coded_cnt   = '0;
      part_byte   = '0;
      part_cnt    = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_word();
      if (cfg_we_i) data_bits_q = cfg_data_i;
      if (in_valid_i && in_ready_i) decode_coded(coded_byte_i, restart_i);
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    decoded_o    <= words_seen;
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

  // Longest quiet stretch allowed: a setting change pause plus a full
  // 264-bit codeword decode, taken several times over.
  localparam int QuietLimit  = 8000;
  // Cycles to hold off after the last expected data word, long enough for
  // the block to finish codewords that yield no data word.
  localparam int DrainCycles = 1200;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [7:0] cfg_data   = 8'd0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] coded_byte = 8'd0;
  logic       restart    = 1'b0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] data_byte;
  logic       error_seen;
  logic       last;

  int fail_count, pending, decoded;
  int send_idle_pct = 9;
  int recv_idle_pct = 54;
  int words_sent    = 0;
  int settings      = 1;
  int quiet         = 0;
  int cur_d         = 11;    // effective data length the encoder follows
  logic restart_next = 1'b0; // raise restart on the next coded word
  logic line_bits [$];       // coded bits not yet packed into a word

  hamming_stream_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .coded_byte_i(coded_byte),
    .restart_i   (restart),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .data_byte_o (data_byte),
    .error_seen_o(error_seen),
    .last_o      (last)
  );

  hsd_checker u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .coded_byte_i(coded_byte),
    .restart_i   (restart),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .data_byte_i (data_byte),
    .error_seen_i(error_seen),
    .last_i      (last),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .decoded_o   (decoded)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random with the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, QuietLimit);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int code_len(input int d);
    int k;
    k = 1;
    while ((1 << k) < k + d + 1) k++;
    return d + k;
  endfunction

  // Offer one coded word and hold it until the block takes it. Called at a
  // rising edge; returns at the edge where the word was accepted.
  task automatic send_word(input logic [7:0] cb, input logic rs);
    // first third: sender mostly busy, receiver lazy; then swapped; then flat out
    if (words_sent < 103) begin
      send_idle_pct = 9;
      recv_idle_pct = 54;
    end else if (words_sent < 206) begin
      send_idle_pct = 54;
      recv_idle_pct = 9;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    coded_byte <= cb;
    restart    <= rs;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Pack whole words off the front of the bit line and send them.
  task automatic flush_line();
    logic [7:0] cb;
    while (line_bits.size() >= 8) begin
      for (int i = 7; i >= 0; i--) cb[i] = line_bits.pop_front();
      send_word(cb, restart_next);
      restart_next = 1'b0;
    end
  endtask

  // Fill the last partial word with random bits and send it.
  task automatic pad_line();
    while (line_bits.size() % 8 != 0) line_bits = {line_bits, 1'($urandom_range(1))};
    flush_line();
  endtask

  // Drop unsent bits and realign: the next word carries restart.
  task automatic start_line();
    line_bits.delete();
    restart_next = 1'b1;
  endtask

  // Append one valid codeword with random data, then flip the bits at
  // pos_a and pos_b (1-based, 0 for none).
  task automatic add_codeword(input int pos_a, input int pos_b);
    int n, syn;
    logic cw [$];
    logic b;
    n   = code_len(cur_d);
    syn = 0;
    for (int p = 1; p <= n; p++) begin
      b = ((p & (p - 1)) != 0) ? 1'($urandom_range(1)) : 1'b0;
      cw = {cw, b};
      if (b) syn ^= p;
    end
    // set the parity bits so the clean codeword has a zero syndrome
    for (int i = 0; (1 << i) <= n; i++) cw[(1 << i) - 1] = syn[i];
    if (pos_a > 0) cw[pos_a - 1] = !cw[pos_a - 1];
    if (pos_b > 0) cw[pos_b - 1] = !cw[pos_b - 1];
    line_bits = {line_bits, cw};
    flush_line();
  endtask

  // Finish the current line, let the block drain, then change the length.
  // No restart is forced, so leftover coded bits meet the new length.
  task automatic set_length(input logic [7:0] v);
    pad_line();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_d = (v == 8'd0) ? 1 : int'(v);
    settings++;
  endtask

  // Mostly well-formed codewords with random data and errors; the rest is
  // noise, mid-stream restarts and truncated codewords.
  task automatic run_phase(input int quota);
    int stop, r, n;
    stop = words_sent + quota;
    if ($urandom_range(3) != 0) start_line();
    while (words_sent < stop) begin
      n = code_len(cur_d);
      r = $urandom_range(99);
      if (r < 45) begin
        add_codeword(0, 0);
      end else if (r < 65) begin
        add_codeword($urandom_range(n, 1), 0);
      end else if (r < 75) begin
        add_codeword($urandom_range(n, 1), $urandom_range(n, 1));
      end else if (r < 85) begin
        repeat (8) line_bits = {line_bits, 1'($urandom_range(1))};
        flush_line();
      end else if (r < 92) begin
        start_line();
        add_codeword($urandom_range(n, 0), 0);
      end else begin
        repeat ($urandom_range(n - 1, 1)) line_bits = {line_bits, 1'($urandom_range(1))};
        flush_line();
      end
    end
  endtask

  initial begin
    int len_plan [10];
    logic [7:0] next_len;
    len_plan = '{255, 1, 5, 11, 26, 64, 120, -1, 3, -1};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset length (11 data bits, 15-bit codewords): extreme words first.
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    start_line();
    add_codeword(0, 0);    // clean
    add_codeword(3, 0);    // data bit error, repaired
    add_codeword(8, 0);    // parity bit error, data untouched
    add_codeword(15, 0);   // error in the last position
    add_codeword(6, 11);   // double error, miscorrected

    // 8 data bits, 12-bit codewords: syndrome past the end of the codeword, then an error in the last position.
    set_length(8'd8);
    start_line();
    add_codeword(5, 10);
    add_codeword(12, 0);

    // Zero length acts as one data bit per 3-bit codeword.
    set_length(8'd0);
    start_line();
    add_codeword(0, 0);
    add_codeword(3, 0);
    add_codeword(1, 0);
    add_codeword(2, 0);
    repeat (4) add_codeword(0, 0);

    foreach (len_plan[i]) begin
      next_len = (len_plan[i] < 0) ? 8'($urandom_range(255)) : 8'(len_plan[i]);
      set_length(next_len);
      run_phase((len_plan[i] == 255) ? 66 : 25);
    end

    pad_line();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Fed %0d coded words over %0d codeword lengths, with restarts and bit errors;",
             words_sent, settings);
    $display("compared %0d decoded data words.", decoded);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/hsd_pkg.sv
rtl/core/hsd_bit_mem.sv
rtl/core/hsd_out_stage.sv
rtl/core/hsd_core.sv
rtl/core/hamming_stream_decoder.sv
sim/hsd_checker.sv
sim/tb.sv
